// ----- hw/rtl/mb4_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mb4_pkg;
  localparam int IMAGE_WIDTH_DEF   = 1024;
  localparam int IMAGE_HEIGHT_DEF  = 1024;
  localparam int FRACTION_BITS_DEF = 28;
  localparam int COORD_W = 10;
  localparam int COUNT_W = 16;
  localparam int CFG_W   = 32;
  localparam int STEP_W  = 29;
  localparam int VAL_W   = 48;

  localparam logic [1:0] REG_STEP   = 2'd0;
  localparam logic [1:0] REG_ORIG_R = 2'd1;
  localparam logic [1:0] REG_ORIG_I = 2'd2;
  localparam logic [1:0] REG_LIMIT  = 2'd3;

  typedef struct packed {
    logic                    outside;
    logic signed [VAL_W-1:0] cr;
    logic signed [VAL_W-1:0] ci;
  } job_t;
endpackage
`default_nettype wire

// ----- hw/rtl/mb4_fxmul.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mb4_fxmul #(
  parameter int FRACTION_BITS = mb4_pkg::FRACTION_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  input  wire  signed [mb4_pkg::VAL_W-1:0] a,
  input  wire  signed [mb4_pkg::VAL_W-1:0] b,
  output logic                             done,
  output logic signed [mb4_pkg::VAL_W-1:0] p
);
  localparam int W = mb4_pkg::VAL_W;
  localparam int H = W / 2;
  logic [W-1:0] ua_r, ub_r;
  logic neg_r;
  logic run_r;
  logic [1:0] ph_r;
  logic [2*W-1:0] acc_r;
  logic [H-1:0] pa, pb;
  logic [W-1:0] prod;
  logic [2*W-1:0] pp, mag;

  always_comb begin
    pa = ph_r[1] ? ua_r[W-1:H] : ua_r[H-1:0];
    pb = ph_r[0] ? ub_r[W-1:H] : ub_r[H-1:0];
    prod = W'(pa) * W'(pb);
    pp = {{W{1'b0}}, prod} << (H * (32'(ph_r[1]) + 32'(ph_r[0])));
    mag = acc_r >> FRACTION_BITS;
    p = neg_r ? -$signed(mag[W-1:0]) : $signed(mag[W-1:0]);
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      ua_r  <= a[W-1] ? W'(-a) : W'(a);
      ub_r  <= b[W-1] ? W'(-b) : W'(b);
      neg_r <= a[W-1] ^ b[W-1];
      ph_r  <= 2'd0;
      acc_r <= '0;
      run_r <= 1'b1;
    end else if (run_r) begin
      acc_r <= acc_r + pp;
      ph_r  <= ph_r + 2'd1;
      if (ph_r == 2'd3) begin
        done  <= 1'b1;
        run_r <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mb4_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mb4_front #(
  parameter int IMAGE_WIDTH  = mb4_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = mb4_pkg::IMAGE_HEIGHT_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire  [mb4_pkg::COORD_W-1:0]        in_pixel_col,
  input  wire  [mb4_pkg::COORD_W-1:0]        in_pixel_row,
  input  wire  [mb4_pkg::STEP_W-1:0]         step,
  input  wire  signed [mb4_pkg::CFG_W-1:0]   org_r,
  input  wire  signed [mb4_pkg::CFG_W-1:0]   org_i,
  output logic                               q_valid,
  input  wire                                q_ready,
  output mb4_pkg::job_t                      q_job
);
  localparam int W = mb4_pkg::VAL_W;
  mb4_pkg::job_t buf_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic push, pop;
  mb4_pkg::job_t job;

  always_comb begin
    job.outside = (32'(in_pixel_col) >= IMAGE_WIDTH) || (32'(in_pixel_row) >= IMAGE_HEIGHT);
    job.cr = $signed(W'({in_pixel_col} * step)) + W'(org_r);
    job.ci = $signed(W'({in_pixel_row} * step)) + W'(org_i);
    in_ready = cnt_r != 2'd2;
    push = in_valid && in_ready;
    q_valid = cnt_r != 2'd0;
    pop = q_valid && q_ready;
    q_job = buf_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= job;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/mb4_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mb4_back #(
  parameter int FRACTION_BITS = mb4_pkg::FRACTION_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_valid,
  output logic                         q_ready,
  input  wire mb4_pkg::job_t           q_job,
  input  wire  [mb4_pkg::COUNT_W-1:0]  limit,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [mb4_pkg::COUNT_W-1:0]  out_iteration_count,
  output logic                         out_escaped
);
  localparam int W = mb4_pkg::VAL_W;
  localparam logic signed [W-1:0] FOUR = W'(4) <<< FRACTION_BITS;
  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_CHK, S_M1, S_M2, S_M3, S_UPD, S_OUT
  } state_t;
  state_t st_r;
  logic signed [W-1:0] cr_r, ci_r, zr_r, zi_r, zr2_r, zi2_r, t1_r, t2_r, t3_r, t4_r;
  logic [mb4_pkg::COUNT_W-1:0] cnt_r;
  logic signed [W-1:0] ma0, mb0, ma1, mb1, p0, p1;
  logic go, d0, d1;
  logic signed [W-1:0] nr, ni;

  mb4_fxmul #(.FRACTION_BITS(FRACTION_BITS)) u_m0 (
    .clk(clk), .rst_n(rst_n), .start(go), .a(ma0), .b(mb0), .done(d0), .p(p0));
  mb4_fxmul #(.FRACTION_BITS(FRACTION_BITS)) u_m1 (
    .clk(clk), .rst_n(rst_n), .start(go), .a(ma1), .b(mb1), .done(d1), .p(p1));

  function automatic logic signed [W-1:0] sat4(input logic signed [W-1:0] v);
    if (v > FOUR) return FOUR;
    if (v < -FOUR) return -FOUR;
    return v;
  endfunction

  always_comb begin
    ma0 = zr_r; mb0 = zr_r; ma1 = zi_r; mb1 = zi_r;
    unique case (st_r)
      S_CHK: begin ma0 = zr2_r; mb0 = zr2_r; ma1 = zi2_r; mb1 = zi2_r; end
      S_M1:  begin ma0 = zr2_r; mb0 = zi2_r; ma1 = zr2_r; mb1 = zr_r; end
      S_M2:  begin ma0 = zi2_r; mb0 = zi_r;  ma1 = zr2_r; mb1 = zr_r; end
      S_M3:  begin ma0 = t3_r;  mb0 = zi_r;  ma1 = zr_r;  mb1 = t4_r; end
      default: ;
    endcase
    nr = t1_r - 6 * t2_r + t3_r + cr_r;
    ni = 4 * p0 - 4 * p1 + ci_r;
    q_ready = st_r == S_IDLE;
  end

  always_ff @(posedge clk) begin
    go <= 1'b0;
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          if (q_job.outside || limit == '0) begin
            out_iteration_count <= '0; out_escaped <= 1'b0;
            out_valid <= 1'b1; st_r <= S_OUT;
          end else begin
            cr_r <= q_job.cr; ci_r <= q_job.ci; zr_r <= '0; zi_r <= '0;
            cnt_r <= '0; go <= 1'b1; st_r <= S_SQ;
          end
        end
        S_SQ: if (d0) begin
          zr2_r <= p0; zi2_r <= p1;
          if (p0 + p1 >= FOUR) begin
            out_iteration_count <= cnt_r; out_escaped <= cnt_r != limit;
            out_valid <= 1'b1; st_r <= S_OUT;
          end else begin go <= 1'b1; st_r <= S_CHK; end
        end
        S_CHK: if (d0) begin t1_r <= p0; t3_r <= p1; go <= 1'b1; st_r <= S_M1; end
        S_M1: if (d0) begin t2_r <= p0; t4_r <= p1; go <= 1'b1; st_r <= S_M2; end
        S_M2: if (d0) begin
          // new zr waits in the zr2 slot until the cross terms are done
          zr2_r <= sat4(nr);
          t3_r <= t4_r; t4_r <= p0; go <= 1'b1; st_r <= S_M3;
        end
        S_M3: if (d0) begin
          zr_r <= zr2_r; zi_r <= sat4(ni); cnt_r <= cnt_r + 1'b1; st_r <= S_UPD;
        end
        S_UPD: begin
          if (cnt_r == limit) begin
            out_iteration_count <= cnt_r; out_escaped <= 1'b0;
            out_valid <= 1'b1; st_r <= S_OUT;
          end else begin go <= 1'b1; st_r <= S_SQ; end
        end
        S_OUT: if (out_ready) begin out_valid <= 1'b0; st_r <= S_IDLE; end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  logic unused_d1;
  assign unused_d1 = d1;

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == S_OUT) else $error("result without output state");
  a_cnt_le: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_UPD |-> cnt_r <= limit) else $error("count beyond limit");
  a_esc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_escaped |-> out_iteration_count < limit) else $error("bad escape flag");
endmodule
`default_nettype wire

// ----- hw/rtl/multibrot4_escape_time.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel  signals                                   dir
// in       in_valid in_ready in_pixel_col/row        in
// out      out_valid out_ready out_iteration_count   out
// cfg      cfg_we cfg_index cfg_data                 in
// An iteration is five multiply steps on two shared 4-phase multipliers
// plus one update state. A pixel outside the image, or a limit of zero,
// gives its result word without any iteration; output stalls hold the
// result word until it is taken. Front queue holds two words.
// Reset is synchronous, active low; both sides stall independently.
module multibrot4_escape_time #(
  parameter int IMAGE_WIDTH   = mb4_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT  = mb4_pkg::IMAGE_HEIGHT_DEF,
  parameter int FRACTION_BITS = mb4_pkg::FRACTION_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [mb4_pkg::COORD_W-1:0]  in_pixel_col,
  input  wire  [mb4_pkg::COORD_W-1:0]  in_pixel_row,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [mb4_pkg::COUNT_W-1:0]  out_iteration_count,
  output logic                         out_escaped,
  input  wire                          cfg_we,
  input  wire  [1:0]                   cfg_index,
  input  wire  [mb4_pkg::CFG_W-1:0]    cfg_data
);
  logic [mb4_pkg::STEP_W-1:0] step_r;
  logic signed [mb4_pkg::CFG_W-1:0] org_r_r, org_i_r;
  logic [mb4_pkg::COUNT_W-1:0] limit_r;
  logic q_valid, q_ready;
  mb4_pkg::job_t q_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 29'd1048576; org_r_r <= 32'shE0000000; org_i_r <= 32'shE0000000;
      limit_r <= 16'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mb4_pkg::REG_STEP:   step_r  <= cfg_data[mb4_pkg::STEP_W-1:0];
        mb4_pkg::REG_ORIG_R: org_r_r <= cfg_data;
        mb4_pkg::REG_ORIG_I: org_i_r <= cfg_data;
        mb4_pkg::REG_LIMIT:  limit_r <= cfg_data[mb4_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  mb4_front #(.IMAGE_WIDTH(IMAGE_WIDTH), .IMAGE_HEIGHT(IMAGE_HEIGHT)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_pixel_col(in_pixel_col), .in_pixel_row(in_pixel_row),
    .step(step_r), .org_r(org_r_r), .org_i(org_i_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job));

  mb4_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .limit(limit_r), .out_valid(out_valid), .out_ready(out_ready),
    .out_iteration_count(out_iteration_count), .out_escaped(out_escaped));
endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  typedef struct {
    bit [mb4_pkg::COUNT_W-1:0] count;
    bit                        escaped;
  } escape_res_t;

  class escape_scoreboard;
    bit [mb4_pkg::STEP_W-1:0]         step;
    logic signed [mb4_pkg::CFG_W-1:0] orig_re;
    logic signed [mb4_pkg::CFG_W-1:0] orig_im;
    bit [mb4_pkg::COUNT_W-1:0]        limit;
    escape_res_t                      pending[$];
    int                               errors;

    function void reset_regs();
      step    = 29'd1048576;
      orig_re = -32'sd536870912;
      orig_im = -32'sd536870912;
      limit   = 16'd50;
    endfunction

    function void set_reg(logic [1:0] idx, bit [mb4_pkg::CFG_W-1:0] val);
      case (idx)
        mb4_pkg::REG_STEP:   step    = val[mb4_pkg::STEP_W-1:0];
        mb4_pkg::REG_ORIG_R: orig_re = val;
        mb4_pkg::REG_ORIG_I: orig_im = val;
        mb4_pkg::REG_LIMIT:  limit   = val[mb4_pkg::COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // product scaled down by the fraction bits, truncated toward zero
    function longint fx_mul(longint a, longint b);
      logic [127:0] ua, ub, p;
      bit neg;
      longint r;
      neg = (a < 0) != (b < 0);
      ua = 128'(a < 0 ? -a : a);
      ub = 128'(b < 0 ? -b : b);
      p = (ua * ub) >> mb4_pkg::FRACTION_BITS_DEF;
      r = longint'({1'b0, p[62:0]});
      return neg ? -r : r;
    endfunction

    function longint clamp4(longint v);
      longint lim;
      lim = longint'(4) <<< mb4_pkg::FRACTION_BITS_DEF;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function void note_pixel(bit [mb4_pkg::COORD_W-1:0] col,
                             bit [mb4_pkg::COORD_W-1:0] row);
      longint cr, ci, zr, zi, zr2, zi2, nr, ni, four;
      int cnt;
      escape_res_t e;
      if (int'(col) >= mb4_pkg::IMAGE_WIDTH_DEF || int'(row) >= mb4_pkg::IMAGE_HEIGHT_DEF) begin
        e.count = '0;
        e.escaped = 1'b0;
        pending.push_back(e);
        return;
      end
      four = longint'(4) <<< mb4_pkg::FRACTION_BITS_DEF;
      zr = 0;
      zi = 0;
      cnt = 0;
      cr = longint'(col) * longint'(step) + longint'(orig_re);
      ci = longint'(row) * longint'(step) + longint'(orig_im);
      while (cnt < int'(limit)) begin
        zr2 = fx_mul(zr, zr);
        zi2 = fx_mul(zi, zi);
        if (zr2 + zi2 >= four) break;
        nr = fx_mul(zr2, zr2) - 6 * fx_mul(zr2, zi2) + fx_mul(zi2, zi2) + cr;
        ni = 4 * fx_mul(fx_mul(zr2, zr), zi) - 4 * fx_mul(zr, fx_mul(zi2, zi)) + ci;
        zr = clamp4(nr);
        zi = clamp4(ni);
        cnt++;
      end
      e.count = cnt[mb4_pkg::COUNT_W-1:0];
      e.escaped = (cnt != int'(limit));
      pending.push_back(e);
    endfunction

    function void check_result(bit [mb4_pkg::COUNT_W-1:0] count, bit escaped);
      escape_res_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word count=%0d escaped=%0b", $time, count, escaped);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (count !== e.count) begin
        $display("%0t: iteration_count expected %0d actual %0d", $time, e.count, count);
        errors++;
      end
      if (escaped !== e.escaped) begin
        $display("%0t: escaped expected %0b actual %0b", $time, e.escaped, escaped);
        errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_CYCLES = 200000;
  localparam int ITEMS = 1150;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [mb4_pkg::COORD_W-1:0]   in_pixel_col;
  logic [mb4_pkg::COORD_W-1:0]   in_pixel_row;
  logic                          out_valid;
  logic                          out_ready;
  logic [mb4_pkg::COUNT_W-1:0]   out_iteration_count;
  logic                          out_escaped;
  logic                          cfg_we;
  logic [1:0]                    cfg_index;
  logic [mb4_pkg::CFG_W-1:0]     cfg_data;

  escape_scoreboard sb;
  bit calm;
  int idle_cycles;
  int sink_hold;
  int sent;

  multibrot4_escape_time DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pixel_col(in_pixel_col), .in_pixel_row(in_pixel_row),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_iteration_count(out_iteration_count), .out_escaped(out_escaped),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_pixel_col, in_pixel_row);
      if (out_valid && out_ready) sb.check_result(out_iteration_count, out_escaped);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else begin
      sink_hold = gap_len();
      out_ready <= (sink_hold == 0);
    end
  end

  task automatic write_reg(logic [1:0] idx, bit [mb4_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(bit [mb4_pkg::CFG_W-1:0] step, bit [mb4_pkg::CFG_W-1:0] ore,
                           bit [mb4_pkg::CFG_W-1:0] oim, bit [mb4_pkg::CFG_W-1:0] lim);
    write_reg(mb4_pkg::REG_STEP, step);
    write_reg(mb4_pkg::REG_ORIG_R, ore);
    write_reg(mb4_pkg::REG_ORIG_I, oim);
    write_reg(mb4_pkg::REG_LIMIT, lim);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(bit [mb4_pkg::COORD_W-1:0] col, bit [mb4_pkg::COORD_W-1:0] row);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_phase();
    int r, n;
    bit [mb4_pkg::CFG_W-1:0] step, ore, oim, lim;
    r = $urandom_range(0, 99);
    n = 110;
    if (r < 70) begin
      step = $urandom_range(1, 1 << 20);
      ore = -$urandom_range(0, 1 << 29);
      oim = -$urandom_range(0, 1 << 29);
      lim = $urandom_range(1, 40);
    end else if (r < 88) begin
      step = $urandom_range(0, 1 << 28);
      ore = $urandom;
      oim = $urandom;
      lim = $urandom_range(1, 200);
    end else begin
      step = $urandom_range(1, 1 << 19);
      ore = -$urandom_range(0, 1 << 28);
      oim = -$urandom_range(0, 1 << 28);
      lim = $urandom_range(100, 600);
      n = 15;
    end
    if (n > ITEMS - sent) n = ITEMS - sent;
    calm = ($urandom_range(0, 3) == 0);
    configure(step, ore, oim, lim);
    repeat (n) send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
    drain();
  endtask

  initial begin
    sb = new();
    sb.reset_regs();
    calm = 1'b0;
    idle_cycles = 0;
    sink_hold = 0;
    sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_col = '0;
    in_pixel_row = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset view, corners and the middle
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(1023, 0);
    send_pixel(0, 1023);
    send_pixel(512, 512);
    send_pixel(341, 682);
    drain();

    // c = 0 never leaves the set
    configure(0, 0, 0, 40);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    drain();

    // no iterations at all
    configure(1 << 20, 0, 0, 0);
    send_pixel(5, 5);
    send_pixel(1023, 0);
    drain();

    // single iteration: far point c = 2 reaches the limit before its escape is checked
    configure(0, 32'h2000_0000, 0, 1);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    drain();

    // extreme registers, points escape after the first iteration
    configure(1 << 28, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(1023, 0);
    drain();
    configure(1 << 28, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
    send_pixel(0, 1023);
    send_pixel(1023, 1023);
    drain();

    while (sent < ITEMS) random_phase();

    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
